>>> hdl/ubh_pkg.sv
`timescale 1ns / 1ps

package ubh_pkg;

   // Field widths of the transaction and register ports
   localparam int DATA_W    = 16;
   localparam int BINS_W    = 7;
   localparam int SEL_W     = 6;
   localparam int MODE_W    = 2;
   localparam int CSR_IDX_W = 2;
   localparam int TOTAL_W   = 16;
   localparam int SAMPLES_W = 32;

   // Defaults for the top-level parameters
   localparam int MAX_BINS_DEF    = 64;
   localparam int COUNT_WIDTH_DEF = 16;

   // Register reset values
   localparam logic signed [DATA_W-1:0] LOWER_RST = 16'sd0;
   localparam logic signed [DATA_W-1:0] UPPER_RST = 16'sd256;
   localparam logic [BINS_W-1:0]        BINS_RST  = 7'd10;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_LOWER = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_UPPER = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_BINS  = 2'd2;

   // Transaction modes
   localparam logic [MODE_W-1:0] MODE_CLEAR  = 2'd0;
   localparam logic [MODE_W-1:0] MODE_ADD    = 2'd1;
   localparam logic [MODE_W-1:0] MODE_READ   = 2'd2;
   localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

   // Controller to datapath commands
   typedef struct packed {
      logic accept;
      logic check;
      logic prep;
      logic div_step;
      logic sweep;
      logic update;
      logic emit;
   } cmd_type;

   // Datapath to controller status
   typedef struct packed {
      logic [MODE_W-1:0] mode;
      logic              hit;
      logic              div_last;
      logic              sweep_last;
   } status_type;

endpackage

>>> hdl/ubh_ram.sv
`timescale 1ns / 1ps

module ubh_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 64
) (
   input  logic                                    clock,
   input  logic                                    wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                        wr_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                        rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write one entry, register the read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> hdl/ubh_ctrl.sv
`timescale 1ns / 1ps

module ubh_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  ubh_pkg::status_type   status,
   output ubh_pkg::cmd_type      cmd
);

   localparam logic [2:0] ST_SWEEP  = 3'd0;
   localparam logic [2:0] ST_IDLE   = 3'd1;
   localparam logic [2:0] ST_CHECK  = 3'd2;
   localparam logic [2:0] ST_PREP   = 3'd3;
   localparam logic [2:0] ST_DIVIDE = 3'd4;
   localparam logic [2:0] ST_LOOKUP = 3'd5;
   localparam logic [2:0] ST_UPDATE = 3'd6;

   logic [2:0] state_ff, state_in;
   logic       clr_rsp_ff, clr_rsp_in;

   // Next state and commands
   always_comb begin
      state_in   = state_ff;
      clr_rsp_in = clr_rsp_ff;
      cmd        = '0;
      unique case (state_ff)
         ST_SWEEP: begin
            cmd.sweep = 1'b1;
            if (status.sweep_last) begin
               cmd.emit   = clr_rsp_ff;
               clr_rsp_in = 1'b0;
               state_in   = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (start) begin
               cmd.accept = 1'b1;
               state_in   = ST_CHECK;
            end
         end
         ST_CHECK: begin
            cmd.check = 1'b1;
            unique case (status.mode)
               ubh_pkg::MODE_CLEAR: begin
                  clr_rsp_in = 1'b1;
                  state_in   = ST_SWEEP;
               end
               ubh_pkg::MODE_ADD: begin
                  if (status.hit) begin
                     state_in = ST_PREP;
                  end else begin
                     cmd.emit = 1'b1;
                     state_in = ST_IDLE;
                  end
               end
               ubh_pkg::MODE_READ: begin
                  state_in = ST_LOOKUP;
               end
               default: begin
                  cmd.emit = 1'b1;
                  state_in = ST_IDLE;
               end
            endcase
         end
         ST_PREP: begin
            cmd.prep = 1'b1;
            state_in = ST_DIVIDE;
         end
         ST_DIVIDE: begin
            cmd.div_step = 1'b1;
            if (status.div_last) begin
               state_in = ST_LOOKUP;
            end
         end
         ST_LOOKUP: begin
            state_in = ST_UPDATE;
         end
         ST_UPDATE: begin
            cmd.update = 1'b1;
            cmd.emit   = 1'b1;
            state_in   = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Hold state; sweep the bins after reset
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_SWEEP;
         clr_rsp_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         clr_rsp_ff <= clr_rsp_in;
      end
   end

   assign busy = (state_ff != ST_IDLE);

endmodule

>>> hdl/ubh_datapath.sv
`timescale 1ns / 1ps

module ubh_datapath #(
   parameter int MAX_BINS    = ubh_pkg::MAX_BINS_DEF,
   parameter int COUNT_WIDTH = ubh_pkg::COUNT_WIDTH_DEF
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  ubh_pkg::cmd_type                        cmd,
   output ubh_pkg::status_type                     status,
   input  logic [ubh_pkg::MODE_W-1:0]              req_mode,
   input  logic signed [ubh_pkg::DATA_W-1:0]       req_sample_value,
   input  logic [ubh_pkg::SEL_W-1:0]               req_bin_select,
   input  logic                                    csr_wr_en,
   input  logic [ubh_pkg::CSR_IDX_W-1:0]           csr_index,
   input  logic [ubh_pkg::DATA_W-1:0]              csr_wr_data,
   output logic                                    rsp_strobe,
   output logic [ubh_pkg::SEL_W-1:0]               rsp_bin_index,
   output logic                                    rsp_in_range,
   output logic [ubh_pkg::TOTAL_W-1:0]             rsp_bin_total,
   output logic [ubh_pkg::SAMPLES_W-1:0]           rsp_samples_total
);

   localparam int DW      = ubh_pkg::DATA_W;
   localparam int BW      = ubh_pkg::BINS_W;
   localparam int NUM_W   = DW + BW;
   localparam int DCNT_W  = $clog2(NUM_W);
   localparam int ADDR_W  = (MAX_BINS > 1) ? $clog2(MAX_BINS) : 1;
   localparam int SW      = ubh_pkg::SAMPLES_W;
   localparam int TW      = ubh_pkg::TOTAL_W;

   localparam logic [DCNT_W-1:0]      DIV_LAST   = DCNT_W'(NUM_W - 1);
   localparam logic [ADDR_W-1:0]      SWEEP_LAST = ADDR_W'(MAX_BINS - 1);
   localparam logic [COUNT_WIDTH-1:0] CNT_MAX    = {COUNT_WIDTH{1'b1}};
   localparam logic [SW-1:0]          SAMPLES_MAX = {SW{1'b1}};
   localparam logic [TW-1:0]          TOTAL_MAX  = {TW{1'b1}};

   // Configuration registers
   logic signed [DW-1:0] lower_ff;
   logic signed [DW-1:0] upper_ff;
   logic [BW-1:0]        bins_ff;

   // Captured transaction
   logic [ubh_pkg::MODE_W-1:0] mode_ff;
   logic signed [DW-1:0]       sample_ff;
   logic [ubh_pkg::SEL_W-1:0]  sel_ff;

   // Sample total
   logic [SW-1:0] samples_ff, samples_in;

   // Divider
   logic [DW-1:0]     off_ff, span_ff;
   logic [NUM_W-1:0]  num_ff, num_in;
   logic [DW-1:0]     rem_ff, rem_in;
   logic [DCNT_W-1:0] dcnt_ff;
   logic [DW:0]       rem_sh;

   // Clearing sweep
   logic [ADDR_W-1:0] sweep_ff;

   // Results
   logic                  strobe_ff;
   logic [ubh_pkg::SEL_W-1:0] idx_res_ff, idx_res_in;
   logic                  hit_res_ff, hit_res_in;
   logic [TW-1:0]         total_res_ff, total_res_in;
   logic [SW-1:0]         samp_res_ff;

   // Combinational helpers
   logic                    hit;
   logic signed [DW:0]      lo17, hi17, x17;
   logic [BW-1:0]           n_raw, n_act, q7, idx7;
   logic                    sel_ok;
   logic [ADDR_W-1:0]       bin_addr;
   logic [COUNT_WIDTH-1:0]  rd_cnt, inc_cnt, res_cnt;
   logic [SW-1:0]           res_cnt32;
   logic                    wr_en;
   logic [ADDR_W-1:0]       wr_addr;
   logic [COUNT_WIDTH-1:0]  wr_data;

   // Write registers
   always_ff @(posedge clock) begin
      if (reset) begin
         lower_ff <= ubh_pkg::LOWER_RST;
         upper_ff <= ubh_pkg::UPPER_RST;
         bins_ff  <= ubh_pkg::BINS_RST;
      end else if (csr_wr_en) begin
         case (csr_index)
            ubh_pkg::CSR_LOWER: lower_ff <= $signed(csr_wr_data);
            ubh_pkg::CSR_UPPER: upper_ff <= $signed(csr_wr_data);
            ubh_pkg::CSR_BINS:  bins_ff  <= csr_wr_data[BW-1:0];
            default: ;
         endcase
      end
   end

   // Range check and bin count
   always_comb begin
      lo17  = {lower_ff[DW-1], lower_ff};
      hi17  = {upper_ff[DW-1], upper_ff};
      x17   = {sample_ff[DW-1], sample_ff};
      hit   = (hi17 > lo17) && (x17 >= lo17) && (x17 <= hi17);
      n_raw = (bins_ff == '0) ? BW'(1) : bins_ff;
      n_act = (32'(n_raw) > MAX_BINS) ? BW'(MAX_BINS) : n_raw;
   end

   // Capture transaction, advance the sample total
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         mode_ff   <= req_mode;
         sample_ff <= req_sample_value;
         sel_ff    <= req_bin_select;
      end
   end

   always_comb begin
      samples_in = samples_ff;
      if (cmd.accept) begin
         if (req_mode == ubh_pkg::MODE_CLEAR) begin
            samples_in = '0;
         end else if (req_mode == ubh_pkg::MODE_ADD && samples_ff != SAMPLES_MAX) begin
            samples_in = samples_ff + SW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         samples_ff <= '0;
      end else begin
         samples_ff <= samples_in;
      end
   end

   // Restoring divider: one quotient bit per cycle, quotient shifts into num
   always_comb begin
      rem_sh = {rem_ff, num_ff[NUM_W-1]};
      if (rem_sh >= {1'b0, span_ff}) begin
         rem_in = DW'(rem_sh - {1'b0, span_ff});
         num_in = {num_ff[NUM_W-2:0], 1'b1};
      end else begin
         rem_in = rem_sh[DW-1:0];
         num_in = {num_ff[NUM_W-2:0], 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.check) begin
         off_ff  <= DW'(x17 - lo17);
         span_ff <= DW'(hi17 - lo17);
      end
      if (cmd.prep) begin
         num_ff <= NUM_W'(off_ff) * NUM_W'(n_act);
         rem_ff <= '0;
      end else if (cmd.div_step) begin
         num_ff <= num_in;
         rem_ff <= rem_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || cmd.prep) begin
         dcnt_ff <= '0;
      end else if (cmd.div_step) begin
         dcnt_ff <= dcnt_ff + DCNT_W'(1);
      end
   end

   // Step the clearing sweep, wrap to zero at the last bin
   always_ff @(posedge clock) begin
      if (reset) begin
         sweep_ff <= '0;
      end else if (cmd.sweep) begin
         sweep_ff <= (sweep_ff == SWEEP_LAST) ? '0 : sweep_ff + ADDR_W'(1);
      end
   end

   // Bin address: the clamped quotient for add, the selected bin for read
   always_comb begin
      q7       = num_ff[BW-1:0];
      idx7     = (q7 >= n_act) ? n_act - BW'(1) : q7;
      sel_ok   = (32'(sel_ff) < MAX_BINS);
      bin_addr = (mode_ff == ubh_pkg::MODE_READ) ? ADDR_W'(sel_ff) : ADDR_W'(idx7);
   end

   // Counter update with saturation
   always_comb begin
      inc_cnt = (rd_cnt == CNT_MAX) ? rd_cnt : rd_cnt + COUNT_WIDTH'(1);
      wr_en   = cmd.sweep || (cmd.update && mode_ff == ubh_pkg::MODE_ADD);
      wr_addr = cmd.sweep ? sweep_ff : bin_addr;
      wr_data = cmd.sweep ? '0 : inc_cnt;
   end

   ubh_ram #(
      .WIDTH (COUNT_WIDTH),
      .DEPTH (MAX_BINS)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (bin_addr),
      .rd_data (rd_cnt)
   );

   // Select the result fields
   always_comb begin
      idx_res_in = '0;
      hit_res_in = 1'b0;
      res_cnt    = '0;
      case (mode_ff)
         ubh_pkg::MODE_ADD: begin
            if (hit) begin
               idx_res_in = ubh_pkg::SEL_W'(idx7);
               hit_res_in = 1'b1;
               res_cnt    = inc_cnt;
            end
         end
         ubh_pkg::MODE_READ: begin
            idx_res_in = sel_ff;
            res_cnt    = sel_ok ? rd_cnt : '0;
         end
         default: ;
      endcase
      res_cnt32    = SW'(res_cnt);
      total_res_in = (res_cnt32 > SW'(TOTAL_MAX)) ? TOTAL_MAX : TW'(res_cnt32);
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         idx_res_ff   <= idx_res_in;
         hit_res_ff   <= hit_res_in;
         total_res_ff <= total_res_in;
         samp_res_ff  <= samples_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         strobe_ff <= 1'b0;
      end else begin
         strobe_ff <= cmd.emit;
      end
   end

   assign status.mode       = mode_ff;
   assign status.hit        = hit;
   assign status.div_last   = (dcnt_ff == DIV_LAST);
   assign status.sweep_last = (sweep_ff == SWEEP_LAST);

   assign rsp_strobe        = strobe_ff;
   assign rsp_bin_index     = idx_res_ff;
   assign rsp_in_range      = hit_res_ff;
   assign rsp_bin_total     = total_res_ff;
   assign rsp_samples_total = samp_res_ff;

endmodule

>>> hdl/uniform_bin_histogram.sv
`timescale 1ns / 1ps

// Histogram of signed Q8.8 samples over [lower_bound, upper_bound] split into
// bins_in_use equal bins. A transaction is taken when start is high and busy
// is low; its one result appears for a single cycle with rsp_strobe and must
// be captured then, as the block cannot be stalled. From acceptance to strobe
// (busy falls in the strobe cycle): an in-range add passes check, prep, the
// 23-step shift-subtract divider that forms the bin index, lookup and update;
// a read passes check, lookup for the registered bin-memory read and update;
// an out-of-range add or an unused mode ends at check; a clear sweeps the
// memory, one bin zeroed per cycle. After reset the same clearing pass runs
// with busy high. Register writes are taken on any cycle and should only come
// while the block is idle.
module uniform_bin_histogram #(
   parameter int MAX_BINS    = ubh_pkg::MAX_BINS_DEF,
   parameter int COUNT_WIDTH = ubh_pkg::COUNT_WIDTH_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic [ubh_pkg::MODE_W-1:0]          req_mode,
   input  logic signed [ubh_pkg::DATA_W-1:0]   req_sample_value,
   input  logic [ubh_pkg::SEL_W-1:0]           req_bin_select,
   input  logic                                csr_wr_en,
   input  logic [ubh_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [ubh_pkg::DATA_W-1:0]          csr_wr_data,
   output logic                                rsp_strobe,
   output logic [ubh_pkg::SEL_W-1:0]           rsp_bin_index,
   output logic                                rsp_in_range,
   output logic [ubh_pkg::TOTAL_W-1:0]         rsp_bin_total,
   output logic [ubh_pkg::SAMPLES_W-1:0]       rsp_samples_total
);

   ubh_pkg::cmd_type    cmd;
   ubh_pkg::status_type status;

   ubh_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .busy   (busy),
      .status (status),
      .cmd    (cmd)
   );

   ubh_datapath #(
      .MAX_BINS    (MAX_BINS),
      .COUNT_WIDTH (COUNT_WIDTH)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .status            (status),
      .req_mode          (req_mode),
      .req_sample_value  (req_sample_value),
      .req_bin_select    (req_bin_select),
      .csr_wr_en         (csr_wr_en),
      .csr_index         (csr_index),
      .csr_wr_data       (csr_wr_data),
      .rsp_strobe        (rsp_strobe),
      .rsp_bin_index     (rsp_bin_index),
      .rsp_in_range      (rsp_in_range),
      .rsp_bin_total     (rsp_bin_total),
      .rsp_samples_total (rsp_samples_total)
   );

endmodule

>>> hdl/ubh_checker.sv
`timescale 1ns / 1ps

module ubh_checker (
   input logic                        clock,
   input logic                        reset,
   input logic                        start,
   input logic                        busy,
   input logic                        rsp_strobe,
   input logic                        rsp_in_range,
   input logic [ubh_pkg::TOTAL_W-1:0] rsp_bin_total
);

   // An accepted transaction makes the block busy in the next cycle
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("busy low right after an accepted transaction");

   // A result closes the work: busy was high before it and is low with it
   a_strobe_ends_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> (!busy && $past(busy)))
      else $error("result strobe not aligned with the end of busy");

   // One result per transaction, never in two consecutive cycles
   a_strobe_single: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe)
      else $error("result strobe high in consecutive cycles");

   // A counted sample leaves its bin at one or more
   a_hit_nonzero: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_in_range) |-> (rsp_bin_total != '0))
      else $error("counted sample reports an empty bin");

endmodule

bind uniform_bin_histogram ubh_checker u_checker (
   .clock         (clock),
   .reset         (reset),
   .start         (start),
   .busy          (busy),
   .rsp_strobe    (rsp_strobe),
   .rsp_in_range  (rsp_in_range),
   .rsp_bin_total (rsp_bin_total)
);
